// ===== src/trng_cht_pkg.sv =====
// Shared constants, types and bit-count helpers for the continuous health test block.
package trng_cht_pkg;

  localparam int WORD_W    = 32;
  localparam int POP_W     = 6;
  localparam int RUN_W     = 8;
  localparam int WIN_WORDS = 32;
  localparam int POS_W     = (WIN_WORDS > 1) ? $clog2(WIN_WORDS) : 1;
  localparam int WIN_BITS  = WIN_WORDS * WORD_W;
  localparam int ONES_W    = $clog2(WIN_BITS + 1);
  localparam int APT_CUT_W = 11;
  localparam int CMP_W     = (ONES_W > APT_CUT_W) ? ONES_W : APT_CUT_W;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 11;

  typedef logic [CFG_ADDR_W-1:0] cfg_addr_t;

  localparam cfg_addr_t CFG_RCT_CUTOFF = 2'd0;
  localparam cfg_addr_t CFG_APT_CUTOFF = 2'd1;
  localparam cfg_addr_t CFG_WARMUP     = 2'd2;

  localparam logic [RUN_W-1:0]     RCT_CUTOFF_RST = 8'd40;
  localparam logic [APT_CUT_W-1:0] APT_CUTOFF_RST = 11'd840;
  localparam logic [RUN_W-1:0]     WARMUP_RST     = 8'd2;

  typedef struct packed {
    logic failed;
    logic warm_ok;
  } rct_res_t;

  typedef struct packed {
    logic failed;
    logic full;
  } apt_res_t;

  // Tree popcount of a 32-bit word.
  function automatic logic [POP_W-1:0] pop32(input logic [WORD_W-1:0] v);
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
    logic [WORD_W-1:0] c;
    logic [WORD_W-1:0] d;
    logic [WORD_W-1:0] e;
    a = v - ((v >> 1) & 32'h5555_5555);
    b = (a & 32'h3333_3333) + ((a >> 2) & 32'h3333_3333);
    c = (b + (b >> 4)) & 32'h0F0F_0F0F;
    d = c + (c >> 8);
    e = d + (d >> 16);
    return e[POP_W-1:0] & 6'h3F;
  endfunction

  function automatic logic [WORD_W-1:0] rev32(input logic [WORD_W-1:0] v);
    logic [WORD_W-1:0] r;
    for (int i = 0; i < WORD_W; i++) begin
      r[i] = v[WORD_W-1-i];
    end
    return r;
  endfunction

endpackage

// ===== src/trng_cht_rct.sv =====
// Repetition count test: run lengths carried across words and the warm-up counter.
module trng_cht_rct (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             fire,
  input  logic                             ok,
  input  logic                             restart,
  input  logic [trng_cht_pkg::WORD_W-1:0]  word,
  input  logic [trng_cht_pkg::RUN_W-1:0]   cutoff,
  input  logic [trng_cht_pkg::RUN_W-1:0]   warmup_words,
  output trng_cht_pkg::rct_res_t           res
);

  logic [trng_cht_pkg::RUN_W-1:0]  zero_run_r, zero_run_nxt;
  logic [trng_cht_pkg::RUN_W-1:0]  one_run_r, one_run_nxt;
  logic [trng_cht_pkg::RUN_W-1:0]  warm_r, warm_nxt, warm_base;
  logic [trng_cht_pkg::WORD_W-1:0] rw;
  logic [trng_cht_pkg::POP_W-1:0]  tz, to, lz, lo;
  logic [trng_cht_pkg::RUN_W:0]    zsum, osum;
  logic                            fail, pass;

  // Masks of the trailing equal bits turn each count into a popcount.
  assign rw = trng_cht_pkg::rev32(word);
  assign tz = trng_cht_pkg::pop32(~word & (word - 32'd1));
  assign to = trng_cht_pkg::pop32(word & ~(word + 32'd1));
  assign lz = trng_cht_pkg::pop32(~rw & (rw - 32'd1));
  assign lo = trng_cht_pkg::pop32(rw & ~(rw + 32'd1));

  assign zsum = {3'b000, tz} + {1'b0, zero_run_r};
  assign osum = {3'b000, to} + {1'b0, one_run_r};

  assign fail = ok && ((zsum >= {1'b0, cutoff}) || (osum >= {1'b0, cutoff}));
  assign pass = ok && !fail;

  // A uniform word extends the carried run; the sum then already holds it.
  always_comb begin
    if (word == '0) begin
      zero_run_nxt = zsum[trng_cht_pkg::RUN_W] ? 8'hFF : zsum[trng_cht_pkg::RUN_W-1:0];
    end else begin
      zero_run_nxt = {2'b00, lz};
    end
    if (word == '1) begin
      one_run_nxt = osum[trng_cht_pkg::RUN_W] ? 8'hFF : osum[trng_cht_pkg::RUN_W-1:0];
    end else begin
      one_run_nxt = {2'b00, lo};
    end
  end

  assign warm_base = restart ? '0 : warm_r;
  assign warm_nxt  = (pass && (warm_base < warmup_words)) ? warm_base + 8'd1 : warm_base;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zero_run_r <= '0;
      one_run_r  <= '0;
      warm_r     <= '0;
    end else if (fire) begin
      warm_r <= warm_nxt;
      if (pass) begin
        zero_run_r <= zero_run_nxt;
        one_run_r  <= one_run_nxt;
      end
    end
  end

  assign res.failed  = fail;
  assign res.warm_ok = (warm_nxt >= warmup_words);

endmodule

// ===== src/trng_cht_apt.sv =====
// Adaptive proportion test: sliding window of per-word popcounts and its bounds check.
module trng_cht_apt (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               fire,
  input  logic                               ok,
  input  logic                               restart,
  input  logic [trng_cht_pkg::WORD_W-1:0]    word,
  input  logic [trng_cht_pkg::APT_CUT_W-1:0] cutoff,
  output trng_cht_pkg::apt_res_t             res
);

  logic [trng_cht_pkg::POP_W-1:0]  pops_r [trng_cht_pkg::WIN_WORDS];
  logic [trng_cht_pkg::POS_W-1:0]  pos_r, pos_nxt;
  logic [trng_cht_pkg::ONES_W-1:0] ones_r, ones_nxt;
  logic                            full_r, full_nxt, full_base;
  logic [trng_cht_pkg::POP_W-1:0]  pop, old;
  logic                            wrap;
  logic [trng_cht_pkg::CMP_W-1:0]  ones_x, cut_x, bits_x, lower;

  assign pop  = trng_cht_pkg::pop32(word);
  assign old  = pops_r[pos_r];
  assign wrap = (pos_r == trng_cht_pkg::POS_W'(trng_cht_pkg::WIN_WORDS - 1));

  assign ones_nxt = ones_r - trng_cht_pkg::ONES_W'(old) + trng_cht_pkg::ONES_W'(pop);
  assign pos_nxt  = wrap ? '0 : pos_r + 1'b1;

  assign full_base = restart ? 1'b0 : full_r;
  assign full_nxt  = ok ? (full_base | wrap) : full_base;

  assign ones_x = trng_cht_pkg::CMP_W'(ones_nxt);
  assign cut_x  = trng_cht_pkg::CMP_W'(cutoff);
  assign bits_x = trng_cht_pkg::CMP_W'(trng_cht_pkg::WIN_BITS);
  assign lower  = (bits_x > cut_x) ? bits_x - cut_x : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < trng_cht_pkg::WIN_WORDS; i++) begin
        pops_r[i] <= '0;
      end
      pos_r  <= '0;
      ones_r <= '0;
      full_r <= 1'b0;
    end else if (fire) begin
      full_r <= full_nxt;
      if (ok) begin
        pops_r[pos_r] <= pop;
        pos_r         <= pos_nxt;
        ones_r        <= ones_nxt;
      end
    end
  end

  assign res.failed = ok && full_nxt && ((ones_x > cut_x) || (ones_x < lower));
  assign res.full   = full_nxt;

endmodule

// ===== src/trng_continuous_health_test_core.sv =====
// Top level: input and result registers, configuration registers and the two health tests.
// Pipeline: an accepted beat is held in the input register and then moves to the result
// register, whose valid flag drives out_tvalid; a stalled result register holds it back.
// Throughput: one word per cycle while out_tready keeps the result register draining; the
// test state is updated as a word moves from the input register to the result register.
// Reset: synchronous active-low rst_n clears all run counts, the warm-up count, the whole
// popcount window and the valid flags of both pipeline registers, and loads the defaults.
module trng_continuous_health_test_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] sample_word
  input  logic [1:0]  in_tuser,   // [0] source_ok, [1] restart_warmup
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] data_word
  output logic [4:0]  out_tuser,  // [0] word_valid, [1] rct_failed, [2] apt_failed,
                                  // [3] source_failed, [4] powerup_passed
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  trng_cht_pkg::cfg_addr_t cfg_addr,
  input  logic [trng_cht_pkg::CFG_DATA_W-1:0] cfg_data
);

  logic [trng_cht_pkg::RUN_W-1:0]     rct_cutoff_r;
  logic [trng_cht_pkg::APT_CUT_W-1:0] apt_cutoff_r;
  logic [trng_cht_pkg::RUN_W-1:0]     warmup_r;

  logic                              in_valid_r, in_valid_nxt;
  logic [trng_cht_pkg::WORD_W-1:0]   in_word_r;
  logic                              in_ok_r, in_restart_r;
  logic                              out_valid_r, out_valid_nxt;
  logic [trng_cht_pkg::WORD_W-1:0]   out_word_r;
  logic [4:0]                        out_flags_r, out_flags_nxt;

  logic                    in_acc, adv, fire;
  trng_cht_pkg::rct_res_t  rct_res;
  trng_cht_pkg::apt_res_t  apt_res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rct_cutoff_r <= trng_cht_pkg::RCT_CUTOFF_RST;
      apt_cutoff_r <= trng_cht_pkg::APT_CUTOFF_RST;
      warmup_r     <= trng_cht_pkg::WARMUP_RST;
    end else if (cfg_valid) begin
      unique case (cfg_addr)
        trng_cht_pkg::CFG_RCT_CUTOFF: rct_cutoff_r <= cfg_data[trng_cht_pkg::RUN_W-1:0];
        trng_cht_pkg::CFG_APT_CUTOFF: apt_cutoff_r <= cfg_data[trng_cht_pkg::APT_CUT_W-1:0];
        trng_cht_pkg::CFG_WARMUP:     warmup_r     <= cfg_data[trng_cht_pkg::RUN_W-1:0];
        default: ;
      endcase
    end
  end

  // The held word moves on whenever the result register is empty or being drained.
  assign adv       = !out_valid_r || out_tready;
  assign fire      = in_valid_r && adv;
  assign in_tready = !in_valid_r || adv;
  assign in_acc    = in_tvalid && in_tready;

  assign in_valid_nxt  = in_acc ? 1'b1 : (fire ? 1'b0 : in_valid_r);
  assign out_valid_nxt = fire ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);

  trng_cht_rct u_rct (
    .clk          (clk),
    .rst_n        (rst_n),
    .fire         (fire),
    .ok           (in_ok_r),
    .restart      (in_restart_r),
    .word         (in_word_r),
    .cutoff       (rct_cutoff_r),
    .warmup_words (warmup_r),
    .res          (rct_res)
  );

  trng_cht_apt u_apt (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (fire),
    .ok      (in_ok_r),
    .restart (in_restart_r),
    .word    (in_word_r),
    .cutoff  (apt_cutoff_r),
    .res     (apt_res)
  );

  assign out_flags_nxt = {rct_res.warm_ok && apt_res.full,
                          !in_ok_r,
                          apt_res.failed,
                          rct_res.failed,
                          in_ok_r && !rct_res.failed && !apt_res.failed};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_word_r    <= in_tdata;
      in_ok_r      <= in_tuser[0];
      in_restart_r <= in_tuser[1];
    end
    if (fire) begin
      out_word_r  <= in_word_r;
      out_flags_r <= out_flags_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_word_r;
  assign out_tuser  = out_flags_r;

`ifndef SYNTHESIS
  a_src_fail_no_test: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_flags_r[3] |-> !out_flags_r[0] && !out_flags_r[1] && !out_flags_r[2])
    else $error("source failure reported together with a test result");

  a_hold_pending: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && !adv |=> in_valid_r && $stable(in_word_r))
    else $error("held word lost while the result register was stalled");

  a_fire_shows_result: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_valid_r)
    else $error("processed word did not reach the result register");
`endif

endmodule
